FILE: rtl/core/tccw_pkg.sv
// Text console cursor writer: shared package.
// Command codes, state encoding, character constants and inter-module structs.
// No dependencies.
package tccw_pkg;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_BACK   = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_COLOUR = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_POST  = 5'b10000
  } state_t;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [3:0] WHITE_FG     = 4'hF;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_data;
    logic        rd_en;
  } mem_req_t;

  typedef struct packed {
    logic [4:0]  row_now;
    logic [6:0]  column_now;
    logic [7:0]  attribute_now;
    logic [15:0] cell_word;
  } res_t;

endpackage

FILE: rtl/core/text_console_cursor_writer_top.sv
// Text console cursor writer: top level.
// Instantiates tccw_ctrl and tccw_cell_mem, holds the result register. Uses tccw_pkg.
//
// One command in, one result out. Each command passes through transfer and execute,
// plus a read step for a cell read because of the registered memory
// read. Clear, and a put that runs past the last row, then sweep all ROWS*COLUMNS
// cells (2000 at 80x25) one cell per cycle, with the input stalled. The result
// register lets the next command transfer while a result waits.
// Cells are undefined after reset until written by a put, backspace or clear.
module text_console_cursor_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_foreground,
  input  logic [3:0]  in_background,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_row_now,
  output logic [6:0]  out_column_now,
  output logic [7:0]  out_attribute_now,
  output logic [15:0] out_cell_word
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW = $clog2(CELL_COUNT);

  tccw_pkg::mem_req_t mem_req;
  tccw_pkg::res_t     res;
  tccw_pkg::res_t     out_r;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [15:0]        mem_rdata;
  logic               res_load;
  logic               slot_free;
  logic               out_valid_r;

  assign slot_free = !out_valid_r || !out_stall;

  tccw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_char_code  (in_char_code),
    .in_foreground (in_foreground),
    .in_background (in_background),
    .in_cell_index (in_cell_index),
    .slot_free     (slot_free),
    .res_load      (res_load),
    .res           (res),
    .mem_req       (mem_req),
    .mem_waddr     (mem_waddr),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  tccw_cell_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_cell_mem (
    .clk   (clk),
    .req   (mem_req),
    .waddr (mem_waddr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_now       = out_r.row_now;
  assign out_column_now    = out_r.column_now;
  assign out_attribute_now = out_r.attribute_now;
  assign out_cell_word     = out_r.cell_word;

endmodule

FILE: rtl/core/tccw_cell_mem.sv
// Text console cursor writer: character-cell memory.
// One write port, one read port, registered read data. Uses tccw_pkg.
module tccw_cell_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                clk,
  input  tccw_pkg::mem_req_t  req,
  input  logic [AW-1:0]       waddr,
  input  logic [AW-1:0]       raddr,
  output logic [15:0]         rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[waddr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tccw_ctrl.sv
// Text console cursor writer: command sequencer.
// Holds cursor, attribute and sweep counter; drives the cell memory. Uses tccw_pkg.
module tccw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_command,
  input  logic [7:0]          in_char_code,
  input  logic [3:0]          in_foreground,
  input  logic [3:0]          in_background,
  input  logic [10:0]         in_cell_index,
  input  logic                slot_free,
  output logic                res_load,
  output tccw_pkg::res_t      res,
  output tccw_pkg::mem_req_t  mem_req,
  output logic [AW-1:0]       mem_waddr,
  output logic [AW-1:0]       mem_raddr,
  input  logic [15:0]         mem_rdata
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
  localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

  tccw_pkg::state_t state_r, state_nxt;
  logic [2:0]    cmd_r;
  logic [7:0]    char_r;
  logic [3:0]    fg_r;
  logic [3:0]    bg_r;
  logic [10:0]   idx_r;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [15:0]   word_r, word_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [15:0]   blank_r, blank_nxt;

  logic          accept;
  logic [AW-1:0] base;
  logic          idx_ok;
  logic          at_origin;

  assign in_stall  = !((state_r == tccw_pkg::ST_IDLE) ||
                       ((state_r == tccw_pkg::ST_POST) && slot_free));
  assign accept    = in_valid && !in_stall;
  assign base      = AW'(row_r) * COLS_A + AW'(col_r);
  assign idx_ok    = int'(idx_r) < CELL_COUNT;
  assign at_origin = (row_r == '0) && (col_r == '0);
  assign mem_raddr = AW'(idx_r);

  assign res_load          = (state_r == tccw_pkg::ST_POST) && slot_free;
  assign res.row_now       = 5'(row_r);
  assign res.column_now    = 7'(col_r);
  assign res.attribute_now = attr_r;
  assign res.cell_word     = word_r;

  always_comb begin
    state_nxt       = state_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    attr_nxt        = attr_r;
    word_nxt        = word_r;
    sweep_nxt       = sweep_r;
    blank_nxt       = blank_r;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_data = {attr_r, char_r};
    mem_req.rd_en   = 1'b0;
    mem_waddr       = base;

    unique case (state_r)
      tccw_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = tccw_pkg::ST_EXEC;
        end
      end
      tccw_pkg::ST_EXEC: begin
        state_nxt = tccw_pkg::ST_POST;
        word_nxt  = '0;
        unique case (cmd_r)
          tccw_pkg::CMD_PUT: begin
            if (char_r != tccw_pkg::NEWLINE_CODE) begin
              mem_req.wr_en = 1'b1;
            end
            if ((char_r == tccw_pkg::NEWLINE_CODE) || (col_r == LAST_COL)) begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                row_nxt   = '0;
                sweep_nxt = '0;
                blank_nxt = {4'h0, tccw_pkg::WHITE_FG, tccw_pkg::SPACE_CODE};
                state_nxt = tccw_pkg::ST_SWEEP;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
          tccw_pkg::CMD_BACK: begin
            if (!at_origin) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_data = {attr_r, tccw_pkg::SPACE_CODE};
              mem_waddr       = base - 1'b1;
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end else begin
                row_nxt = row_r - 1'b1;
                col_nxt = LAST_COL;
              end
            end
          end
          tccw_pkg::CMD_CLEAR: begin
            row_nxt   = '0;
            col_nxt   = '0;
            sweep_nxt = '0;
            blank_nxt = {bg_r, tccw_pkg::WHITE_FG, tccw_pkg::SPACE_CODE};
            state_nxt = tccw_pkg::ST_SWEEP;
          end
          tccw_pkg::CMD_COLOUR: begin
            attr_nxt = {bg_r, fg_r};
          end
          tccw_pkg::CMD_READ: begin
            if (idx_ok) begin
              mem_req.rd_en = 1'b1;
              state_nxt     = tccw_pkg::ST_READ;
            end
          end
          default: begin
          end
        endcase
      end
      tccw_pkg::ST_READ: begin
        word_nxt  = mem_rdata;
        state_nxt = tccw_pkg::ST_POST;
      end
      tccw_pkg::ST_SWEEP: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_data = blank_r;
        mem_waddr       = sweep_r;
        sweep_nxt       = sweep_r + 1'b1;
        if (sweep_r == LAST_CELL) begin
          state_nxt = tccw_pkg::ST_POST;
        end
      end
      tccw_pkg::ST_POST: begin
        if (slot_free) begin
          state_nxt = accept ? tccw_pkg::ST_EXEC : tccw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tccw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccw_pkg::ST_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      attr_r  <= tccw_pkg::RESET_ATTR;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      attr_r  <= attr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    sweep_r <= sweep_nxt;
    blank_r <= blank_nxt;
    if (accept) begin
      cmd_r  <= in_command;
      char_r <= in_char_code;
      fg_r   <= in_foreground;
      bg_r   <= in_background;
      idx_r  <= in_cell_index;
    end
  end

endmodule
